// ----- rtl/ftfb_pkg.sv -----
// types and constants shared by the ft1.2 frame builder
package ftfb_pkg;

  localparam int MAX_BYTES = 17;
  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  localparam logic [7:0] BYTE_FIXED_START = 8'h10;
  localparam logic [7:0] BYTE_VAR_START = 8'h68;
  localparam logic [7:0] BYTE_STOP = 8'h16;
  localparam logic [7:0] BYTE_SINGLE = 8'hE5;
  localparam logic [7:0] CTL_PRM = 8'h40;
  localparam logic [7:0] CTL_ACD = 8'h20;

  localparam logic [3:0] RF_LAST_CONFIRMED = 4'd3;
  localparam logic [3:0] RF_NO_REPLY = 4'd4;
  localparam logic [3:0] RF_REQ_ACCESS = 4'd8;
  localparam logic [3:0] RF_REQ_STATUS = 4'd9;
  localparam logic [3:0] ACK_CONFIRM = 4'd0;
  localparam logic [3:0] ACK_STATUS = 4'd11;
  localparam logic [3:0] ACK_NOT_AVAIL = 4'd15;

  localparam logic [1:0] LEN_TWO = 2'd2;

  typedef enum logic [2:0] {
    CMD_FIXED     = 3'd0,
    CMD_SINGLE    = 3'd1,
    CMD_VAR_START = 3'd2,
    CMD_ELEMENT   = 3'd3,
    CMD_ACK       = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_LINK_ADDR_LEN   = 3'd0,
    CFG_LINK_ADDRESS    = 3'd1,
    CFG_CAUSE_LEN       = 3'd2,
    CFG_CAUSE_FLAGS     = 3'd3,
    CFG_COMMON_ADDR_LEN = 3'd4,
    CFG_COMMON_ADDRESS  = 3'd5,
    CFG_INFO_ADDR_LEN   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  link_addr_len;
    logic [15:0] link_address;
    logic [1:0]  cause_len;
    logic [7:0]  cause_flags;
    logic [1:0]  common_addr_len;
    logic [15:0] common_address;
    logic [1:0]  info_addr_len;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        primary_bit;
    logic [3:0]  function_code;
    logic        class1_pending;
    logic [7:0]  type_id;
    logic [5:0]  cause_code;
    logic [6:0]  element_count;
    logic [15:0] info_address;
    logic        two_bytes_each;
    logic [7:0]  element_byte;
    logic [3:0]  received_function;
  } item_t;

  typedef struct packed {
    logic       frame_open;
    logic [7:0] bytes_left;
    logic [7:0] running_sum;
  } state_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] data;
    logic [CNT_W-1:0]          count;
    logic                      ends;
  } burst_t;

endpackage

// ----- rtl/ftfb_in_if.sv -----
// request channel carrying one frame builder command
interface ftfb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic        primary_bit;
  logic [3:0]  function_code;
  logic        class1_pending;
  logic [7:0]  type_id;
  logic [5:0]  cause_code;
  logic [6:0]  element_count;
  logic [15:0] info_address;
  logic        two_bytes_each;
  logic [7:0]  element_byte;
  logic [3:0]  received_function;

  modport source (
    output valid, command, primary_bit, function_code, class1_pending, type_id,
           cause_code, element_count, info_address, two_bytes_each, element_byte,
           received_function,
    input  ready
  );
  modport sink (
    input  valid, command, primary_bit, function_code, class1_pending, type_id,
           cause_code, element_count, info_address, two_bytes_each, element_byte,
           received_function,
    output ready
  );
endinterface

// ----- rtl/ftfb_out_if.sv -----
// byte channel carrying frame bytes with end flag
interface ftfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink (input valid, out_byte, frame_end, output ready);
endinterface

// ----- rtl/ftfb_compose.sv -----
// builds the byte burst and next frame state for one request
module ftfb_compose (
  input  ftfb_pkg::item_t  item,
  input  ftfb_pkg::cfg_t   cfg,
  input  ftfb_pkg::state_t state,
  output ftfb_pkg::burst_t burst,
  output ftfb_pkg::state_t state_next
);
  import ftfb_pkg::*;

  function automatic logic [7:0] ctl_byte(input logic prm, input logic acd,
                                          input logic [3:0] code);
    logic [7:0] c;
    c = {4'h0, code};
    if (prm) c = c | CTL_PRM;
    if (acd) c = c | CTL_ACD;
    return c;
  endfunction

  logic       la2, cl2, ca2, ia2;
  logic [3:0] ack_code;
  logic [7:0] fix_ctl, var_ctl, cause_byte, data_len, frame_len, fix_sum, var_sum;
  logic [7:0] elem_sum, left_dec;
  logic [4:0] p_type, p_ca, p_ia, p_end;

  assign la2 = cfg.link_addr_len == LEN_TWO;
  assign cl2 = cfg.cause_len == LEN_TWO;
  assign ca2 = cfg.common_addr_len == LEN_TWO;
  assign ia2 = cfg.info_addr_len == LEN_TWO;

  always_comb begin
    priority if (item.received_function <= RF_LAST_CONFIRMED) begin
      ack_code = ACK_CONFIRM;
    end else if (item.received_function == RF_REQ_ACCESS ||
                 item.received_function == RF_REQ_STATUS) begin
      ack_code = ACK_STATUS;
    end else begin
      ack_code = ACK_NOT_AVAIL;
    end
  end

  assign var_ctl = ctl_byte(item.primary_bit, item.class1_pending, item.function_code);
  assign fix_ctl = (cmd_t'(item.command) == CMD_ACK)
                   ? ctl_byte(1'b0, item.class1_pending, ack_code) : var_ctl;
  assign fix_sum = fix_ctl + cfg.link_address[7:0] + (la2 ? cfg.link_address[15:8] : 8'h00);

  assign cause_byte = {2'b00, item.cause_code} | cfg.cause_flags;
  assign data_len = item.two_bytes_each ? {item.element_count, 1'b0}
                                        : {1'b0, item.element_count};
  assign frame_len = 8'd7 + {7'd0, la2} + {7'd0, cl2} + {7'd0, ca2} + {7'd0, ia2}
                     + data_len;
  assign var_sum = var_ctl + cfg.link_address[7:0]
                   + (la2 ? cfg.link_address[15:8] : 8'h00)
                   + item.type_id + {1'b0, item.element_count} + cause_byte
                   + cfg.common_address[7:0]
                   + (ca2 ? cfg.common_address[15:8] : 8'h00)
                   + item.info_address[7:0]
                   + (ia2 ? item.info_address[15:8] : 8'h00);

  assign p_type = 5'd6 + {4'd0, la2};
  assign p_ca = p_type + 5'd3 + {4'd0, cl2};
  assign p_ia = p_ca + 5'd1 + {4'd0, ca2};
  assign p_end = p_ia + 5'd1 + {4'd0, ia2};

  assign elem_sum = state.running_sum + item.element_byte;
  assign left_dec = state.bytes_left - 8'd1;

  always_comb begin
    burst = '0;
    state_next = state;
    unique case (cmd_t'(item.command))
      CMD_FIXED, CMD_ACK: begin
        state_next.frame_open = 1'b0;
        state_next.bytes_left = '0;
        if (!(cmd_t'(item.command) == CMD_ACK && item.received_function == RF_NO_REPLY)) begin
          burst.data[0] = BYTE_FIXED_START;
          burst.data[1] = fix_ctl;
          burst.data[2] = cfg.link_address[7:0];
          if (la2) begin
            burst.data[3] = cfg.link_address[15:8];
            burst.data[4] = fix_sum;
            burst.data[5] = BYTE_STOP;
            burst.count = CNT_W'(6);
          end else begin
            burst.data[3] = fix_sum;
            burst.data[4] = BYTE_STOP;
            burst.count = CNT_W'(5);
          end
          burst.ends = 1'b1;
        end
      end
      CMD_SINGLE: begin
        state_next.frame_open = 1'b0;
        state_next.bytes_left = '0;
        burst.data[0] = BYTE_SINGLE;
        burst.count = CNT_W'(1);
        burst.ends = 1'b1;
      end
      CMD_VAR_START: begin
        burst.data[0] = BYTE_VAR_START;
        burst.data[1] = frame_len;
        burst.data[2] = frame_len;
        burst.data[3] = BYTE_VAR_START;
        burst.data[4] = var_ctl;
        burst.data[5] = cfg.link_address[7:0];
        burst.data[6] = cfg.link_address[15:8];
        burst.data[p_type] = item.type_id;
        burst.data[p_type + 5'd1] = {1'b0, item.element_count};
        burst.data[p_type + 5'd2] = cause_byte;
        burst.data[p_ca] = cfg.common_address[7:0];
        burst.data[p_ca + 5'd1] = cfg.common_address[15:8];
        burst.data[p_ia] = item.info_address[7:0];
        burst.data[p_ia + 5'd1] = item.info_address[15:8];
        state_next.running_sum = var_sum;
        if (data_len == 8'd0) begin
          burst.data[p_end] = var_sum;
          burst.data[p_end + 5'd1] = BYTE_STOP;
          burst.count = p_end + 5'd2;
          burst.ends = 1'b1;
          state_next.frame_open = 1'b0;
          state_next.bytes_left = '0;
        end else begin
          burst.count = p_end;
          state_next.frame_open = 1'b1;
          state_next.bytes_left = data_len;
        end
      end
      CMD_ELEMENT: begin
        if (state.frame_open && state.bytes_left != 8'd0) begin
          burst.data[0] = item.element_byte;
          state_next.running_sum = elem_sum;
          state_next.bytes_left = left_dec;
          if (left_dec == 8'd0) begin
            burst.data[1] = elem_sum;
            burst.data[2] = BYTE_STOP;
            burst.count = CNT_W'(3);
            burst.ends = 1'b1;
            state_next.frame_open = 1'b0;
          end else begin
            burst.count = CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/ftfb_drain.sv -----
// output buffer that shifts out a burst one byte per cycle while the receiver is ready
module ftfb_drain (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ftfb_pkg::burst_t burst,
  output logic             free,
  ftfb_out_if.source       result
);
  import ftfb_pkg::*;

  logic [MAX_BYTES-1:0][7:0] data;
  logic [CNT_W-1:0]          count;
  logic                      ends;

  assign result.valid = count != '0;
  assign result.out_byte = data[0];
  assign result.frame_end = ends && count == CNT_W'(1);
  assign free = count == '0 || (count == CNT_W'(1) && result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.count;
    end else if (count != '0 && result.ready) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= burst.data;
      ends <= burst.ends;
    end else if (count != '0 && result.ready) begin
      data <= {8'h00, data[MAX_BYTES-1:1]};
    end
  end

endmodule

// ----- rtl/ft12_link_frame_builder.sv -----
// ft1.2 link frame builder top level: config registers, request register, frame state
// a request is registered, composed, then loaded into the output buffer that sends its bytes
// throughput: one byte per cycle while the receiver is ready; a request holds the output
// until its last byte is taken, so element requests without trailer flow at one per cycle
// requests yielding no bytes are absorbed without waiting for the output buffer
// reset: config returns to defaults, no frame open, pipeline empty
module ft12_link_frame_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  ftfb_in_if.sink     item,
  ftfb_out_if.source  result
);
  import ftfb_pkg::*;

  cfg_t   cfg;
  item_t  hold;
  logic   hold_valid;
  state_t state;
  state_t state_next;
  burst_t burst;
  logic   drain_free;
  logic   advance;

  assign advance = hold_valid && (burst.count == '0 || drain_free);
  assign item.ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_addr_len <= 2'd1;
      cfg.link_address <= 16'd1;
      cfg.cause_len <= 2'd1;
      cfg.cause_flags <= 8'd0;
      cfg.common_addr_len <= 2'd1;
      cfg.common_address <= 16'd1;
      cfg.info_addr_len <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LINK_ADDR_LEN:   cfg.link_addr_len <= cfg_data[1:0];
        CFG_LINK_ADDRESS:    cfg.link_address <= cfg_data;
        CFG_CAUSE_LEN:       cfg.cause_len <= cfg_data[1:0];
        CFG_CAUSE_FLAGS:     cfg.cause_flags <= cfg_data[7:0];
        CFG_COMMON_ADDR_LEN: cfg.common_addr_len <= cfg_data[1:0];
        CFG_COMMON_ADDRESS:  cfg.common_address <= cfg_data;
        CFG_INFO_ADDR_LEN:   cfg.info_addr_len <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold.command <= item.command;
      hold.primary_bit <= item.primary_bit;
      hold.function_code <= item.function_code;
      hold.class1_pending <= item.class1_pending;
      hold.type_id <= item.type_id;
      hold.cause_code <= item.cause_code;
      hold.element_count <= item.element_count;
      hold.info_address <= item.info_address;
      hold.two_bytes_each <= item.two_bytes_each;
      hold.element_byte <= item.element_byte;
      hold.received_function <= item.received_function;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  ftfb_compose u_compose (
    .item       (hold),
    .cfg        (cfg),
    .state      (state),
    .burst      (burst),
    .state_next (state_next)
  );

  ftfb_drain u_drain (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && burst.count != '0),
    .burst  (burst),
    .free   (drain_free),
    .result (result)
  );

endmodule

// ----- tb/ft12_link_frame_builder_test.sv -----
// testbench for the ft1.2 link frame builder: directed and random requests checked byte by byte
module ft12_link_frame_builder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ftfb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  ftfb_in_if  item_ch ();
  ftfb_out_if result_ch ();

  ft12_link_frame_builder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  cfg_t        station_cfg;
  logic        frame_open;
  logic [7:0]  elements_left;
  logic [7:0]  frame_sum;
  frame_byte_t expected_bytes[$];
  frame_byte_t got_byte;
  frame_byte_t want_byte;
  int          mismatches = 0;
  int          cycles = 0;
  bit          sender_gaps = 1'b0;
  bit          receiver_stalls = 1'b0;

  always #2 clk = ~clk;

  function automatic void expect_byte(logic [7:0] value, logic last);
    frame_byte_t b;
    b.value = value;
    b.last = last;
    expected_bytes.push_back(b);
  endfunction

  function automatic void expect_sum_byte(logic [7:0] value);
    frame_sum = frame_sum + value;
    expect_byte(value, 1'b0);
  endfunction

  function automatic void expect_trailer();
    expect_byte(frame_sum, 1'b0);
    expect_byte(BYTE_STOP, 1'b1);
  endfunction

  function automatic logic [7:0] field_bytes(logic [1:0] setting);
    return (setting == LEN_TWO) ? 8'd2 : 8'd1;
  endfunction

  function automatic logic [7:0] control_byte(logic prm, logic [3:0] code, logic acd);
    return {4'h0, code} | (prm ? CTL_PRM : 8'h00) | (acd ? CTL_ACD : 8'h00);
  endfunction

  function automatic void expect_fixed_frame(logic [7:0] ctl);
    logic [7:0] sum;
    sum = ctl + station_cfg.link_address[7:0];
    expect_byte(BYTE_FIXED_START, 1'b0);
    expect_byte(ctl, 1'b0);
    expect_byte(station_cfg.link_address[7:0], 1'b0);
    if (station_cfg.link_addr_len == LEN_TWO) begin
      expect_byte(station_cfg.link_address[15:8], 1'b0);
      sum = sum + station_cfg.link_address[15:8];
    end
    expect_byte(sum, 1'b0);
    expect_byte(BYTE_STOP, 1'b1);
  endfunction

  function automatic void predict_frame_bytes(item_t r);
    logic [3:0] answer;
    logic [7:0] data_len;
    logic [7:0] frame_len;
    case (r.command)
      CMD_FIXED: begin
        frame_open = 1'b0;
        elements_left = 8'd0;
        expect_fixed_frame(control_byte(r.primary_bit, r.function_code, r.class1_pending));
      end
      CMD_SINGLE: begin
        frame_open = 1'b0;
        elements_left = 8'd0;
        expect_byte(BYTE_SINGLE, 1'b1);
      end
      CMD_ACK: begin
        frame_open = 1'b0;
        elements_left = 8'd0;
        if (r.received_function != RF_NO_REPLY) begin
          if (r.received_function <= RF_LAST_CONFIRMED) answer = ACK_CONFIRM;
          else if (r.received_function == RF_REQ_ACCESS ||
                   r.received_function == RF_REQ_STATUS) answer = ACK_STATUS;
          else answer = ACK_NOT_AVAIL;
          expect_fixed_frame(control_byte(1'b0, answer, r.class1_pending));
        end
      end
      CMD_VAR_START: begin
        data_len = r.two_bytes_each ? {r.element_count, 1'b0} : {1'b0, r.element_count};
        // control, type and count bytes plus the configured address and cause fields and the element data
        frame_len = 8'd3 + field_bytes(station_cfg.link_addr_len)
                  + field_bytes(station_cfg.cause_len)
                  + field_bytes(station_cfg.common_addr_len)
                  + field_bytes(station_cfg.info_addr_len) + data_len;
        frame_sum = 8'd0;
        expect_byte(BYTE_VAR_START, 1'b0);
        expect_byte(frame_len, 1'b0);
        expect_byte(frame_len, 1'b0);
        expect_byte(BYTE_VAR_START, 1'b0);
        expect_sum_byte(control_byte(r.primary_bit, r.function_code, r.class1_pending));
        expect_sum_byte(station_cfg.link_address[7:0]);
        if (station_cfg.link_addr_len == LEN_TWO)
          expect_sum_byte(station_cfg.link_address[15:8]);
        expect_sum_byte(r.type_id);
        expect_sum_byte({1'b0, r.element_count});
        expect_sum_byte({2'b00, r.cause_code} | station_cfg.cause_flags);
        if (station_cfg.cause_len == LEN_TWO) expect_sum_byte(8'h00);
        expect_sum_byte(station_cfg.common_address[7:0]);
        if (station_cfg.common_addr_len == LEN_TWO)
          expect_sum_byte(station_cfg.common_address[15:8]);
        expect_sum_byte(r.info_address[7:0]);
        if (station_cfg.info_addr_len == LEN_TWO) expect_sum_byte(r.info_address[15:8]);
        if (data_len == 8'd0) begin
          frame_open = 1'b0;
          elements_left = 8'd0;
          expect_trailer();
        end else begin
          frame_open = 1'b1;
          elements_left = data_len;
        end
      end
      CMD_ELEMENT: begin
        if (frame_open && elements_left != 8'd0) begin
          expect_sum_byte(r.element_byte);
          elements_left = elements_left - 8'd1;
          if (elements_left == 8'd0) begin
            frame_open = 1'b0;
            expect_trailer();
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(string what, frame_byte_t want_b, frame_byte_t got_b);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch, %s: expected byte %02h end %0b, got byte %02h end %0b",
               what, want_b.value, want_b.last, got_b.value, got_b.last);
  endfunction

  function automatic item_t random_request(logic [2:0] command);
    logic [63:0] bits;
    item_t       r;
    bits = {$urandom, $urandom};
    r = bits[$bits(item_t)-1:0];
    r.command = command;
    return r;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.link_addr_len = 2'($urandom_range(0, 3));
    c.link_address = 16'($urandom);
    c.cause_len = 2'($urandom_range(0, 3));
    c.cause_flags = 8'($urandom);
    c.common_addr_len = 2'($urandom_range(0, 3));
    c.common_address = 16'($urandom);
    c.info_addr_len = 2'($urandom_range(0, 3));
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_request(item_t r);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.command <= r.command;
    item_ch.primary_bit <= r.primary_bit;
    item_ch.function_code <= r.function_code;
    item_ch.class1_pending <= r.class1_pending;
    item_ch.type_id <= r.type_id;
    item_ch.cause_code <= r.cause_code;
    item_ch.element_count <= r.element_count;
    item_ch.info_address <= r.info_address;
    item_ch.two_bytes_each <= r.two_bytes_each;
    item_ch.element_byte <= r.element_byte;
    item_ch.received_function <= r.received_function;
    do @(posedge clk); while (!item_ch.ready);
    predict_frame_bytes(r);
    @(negedge clk);
  endtask

  task automatic send_command(logic [2:0] command);
    send_request(random_request(command));
  endtask

  task automatic send_start(logic [6:0] count, logic two);
    item_t r;
    r = random_request(CMD_VAR_START);
    r.element_count = count;
    r.two_bytes_each = two;
    send_request(r);
  endtask

  task automatic send_element(logic [7:0] value);
    item_t r;
    r = random_request(CMD_ELEMENT);
    r.element_byte = value;
    send_request(r);
  endtask

  task automatic send_ack(logic [3:0] received);
    item_t r;
    r = random_request(CMD_ACK);
    r.received_function = received;
    send_request(r);
  endtask

  task automatic wait_for_drain();
    item_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  task automatic apply_config(cfg_t c);
    wait_for_drain();
    write_reg(CFG_LINK_ADDR_LEN, {14'd0, c.link_addr_len});
    write_reg(CFG_LINK_ADDRESS, c.link_address);
    write_reg(CFG_CAUSE_LEN, {14'd0, c.cause_len});
    write_reg(CFG_CAUSE_FLAGS, {8'd0, c.cause_flags});
    write_reg(CFG_COMMON_ADDR_LEN, {14'd0, c.common_addr_len});
    write_reg(CFG_COMMON_ADDRESS, c.common_address);
    write_reg(CFG_INFO_ADDR_LEN, {14'd0, c.info_addr_len});
    cfg_we <= 1'b0;
    station_cfg = c;
  endtask

  task automatic test_fixed_and_single();
    item_t r;
    r = random_request(CMD_FIXED);
    r.primary_bit = 1'b1;
    r.function_code = 4'hF;
    r.class1_pending = 1'b1;
    send_request(r);
    r = random_request(CMD_FIXED);
    r.primary_bit = 1'b0;
    r.function_code = 4'h0;
    r.class1_pending = 1'b0;
    send_request(r);
    send_command(CMD_SINGLE);
  endtask

  task automatic test_acknowledge();
    send_ack(4'd0);
    send_ack(RF_LAST_CONFIRMED);
    send_ack(RF_NO_REPLY);
    send_ack(RF_REQ_ACCESS);
    send_ack(RF_REQ_STATUS);
    send_ack(4'd15);
  endtask

  task automatic test_variable_frames();
    send_start(7'd0, 1'b1);
    send_start(7'd2, 1'b0);
    send_element(8'h00);
    send_element(8'hFF);
    // no frame open, must be dropped
    send_element(8'hA5);
  endtask

  task automatic test_abandoned_frames();
    send_start(7'd1, 1'b1);
    send_command(CMD_SINGLE);
    send_start(7'd3, 1'b0);
    send_start(7'd0, 1'b0);
    // length byte wraps
    send_start(7'd127, 1'b1);
    send_ack(4'd2);
    send_start(7'd1, 1'b0);
    send_command(CMD_UNUSED_FIRST);
    send_command(CMD_UNUSED_LAST);
    send_element(8'h5A);
  endtask

  task automatic test_random_traffic(int target);
    int    sent;
    int    pick;
    int    elements;
    int    stop_at;
    item_t r;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        r = random_request(CMD_VAR_START);
        if ($urandom_range(0, 7) == 0) r.element_count = 7'($urandom_range(6, 127));
        else r.element_count = 7'($urandom_range(0, 5));
        elements = r.two_bytes_each ? 2 * int'(r.element_count) : int'(r.element_count);
        stop_at = elements;
        if (elements > 12 || $urandom_range(0, 9) == 0)
          stop_at = $urandom_range(0, (elements < 8) ? elements : 8);
        send_request(r);
        sent++;
        for (int i = 0; i < stop_at; i++) begin
          if ($urandom_range(0, 19) == 0)
            send_command(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)));
          send_element(8'($urandom));
          sent++;
        end
      end else if (pick < 75) begin
        send_command(CMD_FIXED);
        sent++;
      end else if (pick < 80) begin
        send_command(CMD_SINGLE);
        sent++;
      end else if (pick < 92) begin
        send_command(CMD_ACK);
        sent++;
      end else if (pick < 96) begin
        send_command(CMD_ELEMENT);
      end else begin
        send_command(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)));
      end
      if (sender_gaps && $urandom_range(0, 59) == 0) wait_for_drain();
    end
  endtask

  initial begin
    cfg_t widest;
    cfg_t narrowest;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LINK_ADDR_LEN;
    cfg_data <= 16'd0;
    item_ch.valid <= 1'b0;
    item_ch.command <= CMD_FIXED;
    item_ch.primary_bit <= 1'b0;
    item_ch.function_code <= 4'd0;
    item_ch.class1_pending <= 1'b0;
    item_ch.type_id <= 8'd0;
    item_ch.cause_code <= 6'd0;
    item_ch.element_count <= 7'd0;
    item_ch.info_address <= 16'd0;
    item_ch.two_bytes_each <= 1'b0;
    item_ch.element_byte <= 8'd0;
    item_ch.received_function <= 4'd0;
    station_cfg.link_addr_len = 2'd1;
    station_cfg.link_address = 16'd1;
    station_cfg.cause_len = 2'd1;
    station_cfg.cause_flags = 8'd0;
    station_cfg.common_addr_len = 2'd1;
    station_cfg.common_address = 16'd1;
    station_cfg.info_addr_len = LEN_TWO;
    frame_open = 1'b0;
    elements_left = 8'd0;
    frame_sum = 8'd0;
    widest.link_addr_len = LEN_TWO;
    widest.link_address = 16'hFFFF;
    widest.cause_len = LEN_TWO;
    widest.cause_flags = 8'hFF;
    widest.common_addr_len = LEN_TWO;
    widest.common_address = 16'hFFFF;
    widest.info_addr_len = LEN_TWO;
    narrowest.link_addr_len = 2'd1;
    narrowest.link_address = 16'h0000;
    narrowest.cause_len = 2'd1;
    narrowest.cause_flags = 8'h00;
    narrowest.common_addr_len = 2'd1;
    narrowest.common_address = 16'h0000;
    narrowest.info_addr_len = 2'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    test_fixed_and_single();
    test_acknowledge();
    test_variable_frames();
    test_abandoned_frames();

    apply_config(widest);
    test_random_traffic(90);
    apply_config(narrowest);
    test_random_traffic(90);
    apply_config(random_cfg());
    test_random_traffic(80);
    apply_config(random_cfg());
    test_random_traffic(80);
    apply_config(random_cfg());
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    test_random_traffic(70);
    wait_for_drain();

    if (mismatches == 0) begin
      $display("ft12_link_frame_builder_test: PASS");
    end else begin
      $display("ft12_link_frame_builder_test: FAIL");
    end
    $finish;
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      got_byte.value = result_ch.out_byte;
      got_byte.last = result_ch.frame_end;
      if (expected_bytes.size() == 0) begin
        want_byte.value = 8'h00;
        want_byte.last = 1'b0;
        report_mismatch("byte with no request pending", want_byte, got_byte);
      end else begin
        want_byte = expected_bytes.pop_front();
        if (got_byte.value !== want_byte.value)
          report_mismatch("out_byte", want_byte, got_byte);
        else if (got_byte.last !== want_byte.last)
          report_mismatch("frame_end", want_byte, got_byte);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ft12_link_frame_builder_test: FAIL");
      $finish;
    end
  end

endmodule
